@@ design/ppmd_pkg.sv @@
// Package for the point-to-polyline least squared distance block.
// Holds the beat types, widths, register indexes and sequencer states.
// No dependencies.
package ppmd_pkg;

  localparam int COORD_BITS = 20;
  localparam int DIST_BITS  = 43;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIST_BITS;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_BITS-1:0]         dist_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } vertex_beat_t;

  typedef struct packed {
    dist_t min_dist_sq;
    logic  hit;
  } result_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X    = 2'd0,
    REG_QUERY_Y    = 2'd1,
    REG_HIT_THRESH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_EVAL,
    ST_DSQ,
    ST_DIV,
    ST_INT,
    ST_UPD
  } seq_state_t;

endpackage

@@ design/point_polyline_min_distance.sv @@
// Point-to-polyline least squared distance, top level.
// Depends on ppmd_pkg (beat types, widths, register indexes, states).
//
// Vertices of one polyline arrive one beat at a time; the block keeps the
// least squared distance (Q.8 units, saturated at 2^43-1) from the query
// point to any segment and emits it with a hit flag on the beat marked as
// the last vertex. One shared signed multiplier under a small sequencer does
// all products. When the segment's projection falls outside it, the segment
// has zero length or the vertex is the first, an item runs ST_DIFF, ST_MUL
// and ST_EVAL, then ST_UPD folds its distance into the running least. When
// the projection falls inside, ST_DSQ forms dot^2 and a radix-2 restoring
// divider in ST_DIV produces one quotient bit per cycle, followed by ST_INT
// and ST_UPD. in_stall is high while an item is in work.
// A last-vertex item also waits while a previous result is still held in
// the output register. cfg_ready is always high; the query point and the
// threshold must only be written while no item is in work.
module point_polyline_min_distance (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ppmd_pkg::vertex_beat_t        in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppmd_pkg::result_beat_t        out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppmd_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;       // coordinate difference
  localparam int MUL_W  = COORD_BITS + 3;       // multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 2 * COORD_BITS + 3;   // sum of two squares
  localparam int SUM_W  = SQ_W + 1;             // signed dot product
  localparam int HALF_W = COORD_BITS + 1;       // low half of dot
  localparam int DSQ_W  = 2 * SQ_W;
  localparam int EXT_W  = (SQ_W > DIST_BITS) ? SQ_W : DIST_BITS;
  localparam int CNT_W  = $clog2(SQ_W + 1);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [MUL_W-1:0]  mop_t;

  function automatic dist_t sat_dist(input logic [EXT_W-1:0] v);
    if (v > EXT_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return v[DIST_BITS-1:0];
  endfunction

  seq_state_t state_r, state_nxt;

  // configuration
  coord_t query_x_r, query_y_r;
  dist_t  thresh_r;

  // polyline state
  coord_t prev_x_r, prev_y_r;
  logic   have_prev_r;
  dist_t  best_r;

  // current vertex
  coord_t vx_r, vy_r;
  logic   last_r;

  diff_t apx_r, apy_r, abx_r, aby_r, bpx_r, bpy_r;
  logic [SQ_W-1:0]         ap2_r, len2_r, bp2_r;
  logic signed [SUM_W-1:0] dot_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SQ_W-1:0]  rem_r, quo_r;
  dist_t            d_r;

  logic             out_valid_r;
  result_beat_t     out_data_r;

  mop_t             op_a, op_b;
  logic [2:0]       acc_idx;
  logic [DSQ_W-1:0] pp_ext;
  logic [SQ_W:0]    div_t;
  logic             div_ge;
  logic             eval_zero_len, eval_behind, eval_beyond;
  dist_t            best_upd;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign acc_idx = 3'(cnt_r - 1'b1);
  assign pp_ext  = DSQ_W'($unsigned(prod_r));
  assign div_t   = {rem_r, quo_r[SQ_W-1]};
  assign div_ge  = (div_t >= {1'b0, len2_r});

  assign eval_zero_len = (len2_r == '0);
  assign eval_behind   = (dot_r <= 0);
  assign eval_beyond   = (dot_r[SQ_W-1:0] >= len2_r);

  always_comb begin
    best_upd = best_r;
    if ((have_prev_r || last_r) && (d_r < best_r)) begin
      best_upd = d_r;
    end
  end

  // shared multiplier operand select
  always_comb begin
    op_a = mop_t'(apx_r);
    op_b = mop_t'(apx_r);
    if (state_r == ST_DSQ) begin
      case (cnt_r)
        CNT_W'(0): begin
          op_a = mop_t'(dot_r[HALF_W-1:0]);
          op_b = mop_t'(dot_r[HALF_W-1:0]);
        end
        CNT_W'(1): begin
          op_a = mop_t'(dot_r[SQ_W-1:HALF_W]);
          op_b = mop_t'(dot_r[HALF_W-1:0]);
        end
        default: begin
          op_a = mop_t'(dot_r[SQ_W-1:HALF_W]);
          op_b = mop_t'(dot_r[SQ_W-1:HALF_W]);
        end
      endcase
    end else begin
      case (cnt_r[2:0])
        3'd0: begin op_a = mop_t'(apx_r); op_b = mop_t'(apx_r); end
        3'd1: begin op_a = mop_t'(apy_r); op_b = mop_t'(apy_r); end
        3'd2: begin op_a = mop_t'(abx_r); op_b = mop_t'(abx_r); end
        3'd3: begin op_a = mop_t'(aby_r); op_b = mop_t'(aby_r); end
        3'd4: begin op_a = mop_t'(apx_r); op_b = mop_t'(abx_r); end
        3'd5: begin op_a = mop_t'(apy_r); op_b = mop_t'(aby_r); end
        3'd6: begin op_a = mop_t'(bpx_r); op_b = mop_t'(bpx_r); end
        default: begin op_a = mop_t'(bpy_r); op_b = mop_t'(bpy_r); end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_r == CNT_W'(8)) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!have_prev_r || eval_zero_len || eval_behind || eval_beyond) begin
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_DSQ;
        end
      end
      ST_DSQ: begin
        if (cnt_r == CNT_W'(3)) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(SQ_W - 1)) begin
          state_nxt = ST_INT;
        end
      end
      ST_INT: state_nxt = ST_UPD;
      ST_UPD: begin
        if (!last_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= '0;
      query_y_r <= '0;
      thresh_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_QUERY_X:    query_x_r <= cfg_data[COORD_BITS-1:0];
        REG_QUERY_Y:    query_y_r <= cfg_data[COORD_BITS-1:0];
        REG_HIT_THRESH: thresh_r  <= cfg_data[DIST_BITS-1:0];
        default: ;
      endcase
    end
  end

  // polyline state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      best_r      <= DIST_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPD && last_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_UPD) begin
        if (!last_r) begin
          prev_x_r    <= vx_r;
          prev_y_r    <= vy_r;
          have_prev_r <= 1'b1;
          best_r      <= best_upd;
        end else if (out_free) begin
          prev_x_r    <= '0;
          prev_y_r    <= '0;
          have_prev_r <= 1'b0;
          best_r      <= DIST_MAX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r != state_nxt) begin
      cnt_r <= '0;
    end else if (state_r == ST_MUL || state_r == ST_DSQ || state_r == ST_DIV) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    case (state_r)
      ST_IDLE: begin
        vx_r   <= in_data.vertex_x;
        vy_r   <= in_data.vertex_y;
        last_r <= in_data.last_vertex;
      end
      ST_DIFF: begin
        apx_r <= diff_t'(query_x_r) - diff_t'(prev_x_r);
        apy_r <= diff_t'(query_y_r) - diff_t'(prev_y_r);
        abx_r <= diff_t'(vx_r) - diff_t'(prev_x_r);
        aby_r <= diff_t'(vy_r) - diff_t'(prev_y_r);
        bpx_r <= diff_t'(query_x_r) - diff_t'(vx_r);
        bpy_r <= diff_t'(query_y_r) - diff_t'(vy_r);
      end
      ST_MUL: begin
        // product of the previous step lands here
        if (cnt_r != '0) begin
          case (acc_idx)
            3'd0: ap2_r  <= prod_r[SQ_W-1:0];
            3'd1: ap2_r  <= ap2_r + prod_r[SQ_W-1:0];
            3'd2: len2_r <= prod_r[SQ_W-1:0];
            3'd3: len2_r <= len2_r + prod_r[SQ_W-1:0];
            3'd4: dot_r  <= prod_r[SUM_W-1:0];
            3'd5: dot_r  <= dot_r + prod_r[SUM_W-1:0];
            3'd6: bp2_r  <= prod_r[SQ_W-1:0];
            default: bp2_r <= bp2_r + prod_r[SQ_W-1:0];
          endcase
        end
      end
      ST_EVAL: begin
        if (!have_prev_r || (!eval_zero_len && !eval_behind && eval_beyond)) begin
          d_r <= sat_dist(EXT_W'(bp2_r));
        end else begin
          d_r <= sat_dist(EXT_W'(ap2_r));
        end
      end
      ST_DSQ: begin
        // dot^2 built from half products straight into the divider's dividend
        case (cnt_r)
          CNT_W'(1): {rem_r, quo_r} <= pp_ext;
          CNT_W'(2): {rem_r, quo_r} <= {rem_r, quo_r} + (pp_ext << (HALF_W + 1));
          CNT_W'(3): {rem_r, quo_r} <= {rem_r, quo_r} + (pp_ext << (2 * HALF_W));
          default: ;
        endcase
      end
      ST_DIV: begin
        rem_r <= div_ge ? SQ_W'(div_t - {1'b0, len2_r}) : div_t[SQ_W-1:0];
        quo_r <= {quo_r[SQ_W-2:0], div_ge};
      end
      ST_INT: begin
        if (quo_r > ap2_r) begin
          d_r <= '0;
        end else begin
          d_r <= sat_dist(EXT_W'(ap2_r - quo_r));
        end
      end
      ST_UPD: begin
        if (last_r && out_free) begin
          out_data_r.min_dist_sq <= best_upd;
          out_data_r.hit         <= (best_upd <= thresh_r);
        end
      end
      default: ;
    endcase
  end

endmodule
